[src/djs_pkg.sv]
`default_nettype none
package djs_pkg;

   // task table slots; the 3-bit slot field and 4-bit task_count are sized for it
   localparam int MAX_TASKS = 8;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  slot;
      logic [7:0]  task_id;
      logic [15:0] period;
      logic [15:0] rel_deadline;
      logic [15:0] compute;
   } req_type;

   typedef struct packed {
      logic        run_valid;
      logic [7:0]  run_id;
      logic        missed;
      logic        infeasible;
      logic        overflow;
      logic [31:0] now;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic begin_item; // latch reported tick number, clear run result
      logic load;       // write table slot from the held request
      logic restart;    // start restart sweep
      logic clear_step; // clear one task slot and one job entry
      logic rel_step;   // handle release of current task slot
      logic scan_start; // reset best-job search
      logic scan_step;  // compare one job entry
      logic retire;     // run or miss the selected job
      logic tick_done;  // advance tick number
   } djs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rel_last;
      logic scan_last;
      logic clear_last;
      logic missed;
   } djs_sts_type;

endpackage
`default_nettype wire

[src/djs_datapath.sv]
`default_nettype none
module djs_datapath #(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire djs_pkg::req_type   req_hold,
   input  wire logic [3:0]         task_count,
   input  wire djs_pkg::djs_cmd_type cmd,
   output      djs_pkg::djs_sts_type sts,
   output      djs_pkg::rsp_type   rsp_data
);
   import djs_pkg::*;

   localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = (TW > QW) ? TW : QW;
   localparam logic [CW:0] IDX_ONE = {{CW{1'b0}}, 1'b1};

   // task table, undefined until loaded
   logic [15:0] tperiod [MAX_TASKS];
   logic [15:0] tdead   [MAX_TASKS];
   logic [15:0] tcomp   [MAX_TASKS];
   logic [7:0]  tident  [MAX_TASKS];
   logic [15:0] cdown_ff [MAX_TASKS];

   // job store in memories; valid bits in flops
   logic [31:0] jdl_mem  [QUEUE_DEPTH];
   logic [15:0] jrem_mem [QUEUE_DEPTH];
   logic [2:0]  jslot_mem[QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] jvalid_ff;

   logic [31:0] tick_ff;
   logic [31:0] now_ff;
   logic        missed_ff, infeas_ff, ovf_ff;
   logic [CW:0] idx_ff;
   logic        best_ok_ff;
   logic [QW-1:0] best_ff;
   logic [31:0] best_dl_ff;
   logic [2:0]  best_slot_ff;
   logic [15:0] best_rem_ff;
   logic        ran_ff;
   logic [7:0]  ran_id_ff;

   logic [31:0] rd_dl_ff;
   logic [15:0] rd_rem_ff;
   logic [2:0]  rd_slot_ff;
   logic [QW-1:0] rd_idx_ff;
   logic        rd_vld_ff;
   logic [3:0]  active;
   logic [QW-1:0] free_idx;
   logic        free_ok;
   logic [TW-1:0] ti;
   logic [QW-1:0] qi;
   logic        better;

   assign active = (task_count > 4'(MAX_TASKS)) ? 4'(MAX_TASKS) : task_count;
   assign ti = idx_ff[TW-1:0];
   assign qi = idx_ff[QW-1:0];

   // first free job entry
   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int q = QUEUE_DEPTH - 1; q >= 0; q--) begin
         if (!jvalid_ff[q]) begin
            free_idx = QW'(q);
            free_ok  = 1'b1;
         end
      end
   end

   // compare the entry read in the previous cycle with the best so far
   assign better = rd_vld_ff && (!best_ok_ff || rd_dl_ff < best_dl_ff ||
                   (rd_dl_ff == best_dl_ff && rd_slot_ff < best_slot_ff));

   assign sts.rel_last   = (32'(idx_ff) + 32'd1 >= 32'(active)) || (active == 4'd0);
   assign sts.scan_last  = (32'(idx_ff) == QUEUE_DEPTH);
   assign sts.clear_last = (32'(idx_ff) == QUEUE_DEPTH - 1);
   assign sts.missed     = missed_ff;

   // table and job memories
   always_ff @(posedge clock) begin
      if (cmd.load && 32'(req_hold.slot) < MAX_TASKS) begin
         tperiod[req_hold.slot[TW-1:0]] <= req_hold.period;
         tdead[req_hold.slot[TW-1:0]]   <= req_hold.rel_deadline;
         tcomp[req_hold.slot[TW-1:0]]   <= req_hold.compute;
         tident[req_hold.slot[TW-1:0]]  <= req_hold.task_id;
      end
      if (cmd.rel_step && active != 4'd0 && cdown_ff[ti] == 16'd0 && free_ok) begin
         jdl_mem[free_idx]   <= tick_ff + 32'(tdead[ti]);
         jrem_mem[free_idx]  <= tcomp[ti];
         jslot_mem[free_idx] <= 3'(ti);
      end else if (cmd.retire && best_ok_ff && best_dl_ff > tick_ff) begin
         jrem_mem[best_ff] <= best_rem_ff - 16'd1;
      end
      // registered read at the scan index
      rd_dl_ff   <= jdl_mem[qi];
      rd_rem_ff  <= jrem_mem[qi];
      rd_slot_ff <= jslot_mem[qi];
      rd_idx_ff  <= qi;
   end

   // capture the best job entry
   always_ff @(posedge clock) begin
      if (better) begin
         best_ff      <= rd_idx_ff;
         best_dl_ff   <= rd_dl_ff;
         best_slot_ff <= rd_slot_ff;
         best_rem_ff  <= rd_rem_ff;
      end
   end

   // control state of datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_TASKS; s++) cdown_ff[s] <= '0;
         jvalid_ff  <= '0;
         tick_ff    <= '0;
         now_ff     <= '0;
         missed_ff  <= 1'b0;
         infeas_ff  <= 1'b0;
         ovf_ff     <= 1'b0;
         idx_ff     <= '0;
         best_ok_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         ran_ff     <= 1'b0;
         ran_id_ff  <= '0;
      end else begin
         // latch the tick number this transaction reports
         if (cmd.begin_item) begin
            ran_ff <= 1'b0;
            now_ff <= cmd.restart ? 32'd0 : tick_ff;
         end
         if (cmd.load) begin
            if (req_hold.rel_deadline < req_hold.compute) infeas_ff <= 1'b1;
            if (32'(req_hold.slot) < MAX_TASKS) cdown_ff[req_hold.slot[TW-1:0]] <= '0;
         end
         if (cmd.restart) begin
            tick_ff   <= '0;
            missed_ff <= 1'b0;
            ovf_ff    <= 1'b0;
         end
         if (cmd.clear_step) begin
            if (32'(idx_ff) < MAX_TASKS) cdown_ff[ti] <= '0;
            jvalid_ff[qi] <= 1'b0;
         end
         if (cmd.rel_step && active != 4'd0) begin
            if (cdown_ff[ti] == 16'd0) begin
               cdown_ff[ti] <= tperiod[ti] - 16'd1;
               if (free_ok) jvalid_ff[free_idx] <= 1'b1;
               else ovf_ff <= 1'b1;
            end else begin
               cdown_ff[ti] <= cdown_ff[ti] - 16'd1;
            end
         end
         // advance the shared slot and entry index
         if (cmd.begin_item || cmd.scan_start) idx_ff <= '0;
         else if (cmd.clear_step || cmd.rel_step || cmd.scan_step) idx_ff <= idx_ff + IDX_ONE;
         rd_vld_ff <= cmd.scan_step && (32'(idx_ff) < QUEUE_DEPTH) && jvalid_ff[qi];
         if (cmd.scan_start) best_ok_ff <= 1'b0;
         else if (better) best_ok_ff <= 1'b1;
         if (cmd.retire && best_ok_ff) begin
            if (best_dl_ff <= tick_ff) begin
               missed_ff <= 1'b1;
            end else begin
               ran_ff    <= 1'b1;
               ran_id_ff <= tident[best_slot_ff[TW-1:0]];
               if (best_rem_ff <= 16'd1) jvalid_ff[best_ff] <= 1'b0;
            end
         end
         if (cmd.tick_done) tick_ff <= tick_ff + 32'd1;
      end
   end

   // result: tick reports number before advance
   always_comb begin
      rsp_data.run_valid  = ran_ff;
      rsp_data.run_id     = ran_ff ? ran_id_ff : 8'd0;
      rsp_data.missed     = missed_ff;
      rsp_data.infeasible = infeas_ff;
      rsp_data.overflow   = ovf_ff;
      rsp_data.now        = now_ff;
   end

   // a job never runs once the miss flag is up
   assert property (@(posedge clock) disable iff (reset)
      missed_ff && cmd.retire |=> !ran_ff)
      else $error("job ran after miss");
   // restart clears the tick number
   assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> tick_ff == 32'd0)
      else $error("restart left tick number");
   // infeasible flag is sticky
   assert property (@(posedge clock) disable iff (reset)
      infeas_ff |=> infeas_ff)
      else $error("infeasible flag dropped");
endmodule
`default_nettype wire

[src/djs_control.sv]
`default_nettype none
module djs_control (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [1:0]           req_command,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic                 hold_en,
   input  wire djs_pkg::djs_sts_type sts,
   output      djs_pkg::djs_cmd_type cmd
);
   import djs_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_DECODE  = 7'b0000010,
      ST_CLEAR   = 7'b0000100,
      ST_RELEASE = 7'b0001000,
      ST_SCAN    = 7'b0010000,
      ST_RETIRE  = 7'b0100000,
      ST_RESP    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] cmd_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign hold_en   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (hold_en) cmd_ff <= req_command;
      end
   end

   // sequence one transaction
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.begin_item = 1'b1;
            case (cmd_ff)
               CMD_LOAD: begin
                  cmd.load = 1'b1;
                  state_in = ST_RESP;
               end
               CMD_TICK: begin
                  if (sts.missed) begin
                     cmd.tick_done = 1'b1;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_RELEASE;
                  end
               end
               CMD_RESTART: begin
                  cmd.restart = 1'b1;
                  state_in = ST_CLEAR;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_RESP;
         end
         ST_RELEASE: begin
            cmd.rel_step = 1'b1;
            if (sts.rel_last) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = ST_RETIRE;
         end
         ST_RETIRE: begin
            cmd.retire    = 1'b1;
            cmd.tick_done = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      hold_en |=> state_ff == ST_DECODE)
      else $error("accepted transaction not decoded");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.restart, cmd.scan_step, cmd.clear_step}))
      else $error("conflicting datapath commands");
endmodule
`default_nettype wire

[src/deadline_job_scheduler.sv]
// Earliest-deadline-first tick scheduler.
// req channel: one transaction carries a command (load slot, tick,
// restart) and task fields. rsp channel: one result per transaction with
// the running task id, sticky miss/infeasible/overflow flags and the tick
// number. csr channel: writes task_count (active table slots).
// Steps: a load decodes and answers; a tick runs one release step per
// active slot (one step when none is active), a scan over every job entry
// through the registered store read, then retire; a tick after a miss
// skips release, scan and retire but still advances the tick number;
// restart runs a clearing pass over the store. One transaction is in
// flight at a time; req_ready is high only while idle, so a new request
// is taken only after the result has been accepted. The result holds in
// its register while rsp_ready is low. Reset clears jobs, flags, the tick
// number and sets task_count to 1; the task table is undefined until
// loaded.
`default_nettype none
module deadline_job_scheduler #(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire djs_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      djs_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [3:0]       csr_data
);
   import djs_pkg::*;

   req_type     req_ff;
   logic [3:0]  count_ff;
   logic        hold_en;
   djs_cmd_type cmd;
   djs_sts_type sts;

   assign csr_ready = 1'b1;

   // hold request and register
   always_ff @(posedge clock) begin
      if (hold_en) req_ff <= req_data;
      if (reset) count_ff <= 4'd1;
      else if (csr_valid) count_ff <= csr_data;
   end

   djs_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_command(req_data.command),
      .rsp_valid, .rsp_ready, .hold_en, .sts, .cmd
   );

   djs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock, .reset, .req_hold(req_ff), .task_count(count_ff),
      .cmd, .sts, .rsp_data
   );
endmodule
`default_nettype wire
